FILE: rtl/ibc_pkg.sv
// ibc_pkg: shared types and constants for the IMU bias calibrator.
// No dependencies; used by ibc_axis_lane, ibc_cal_seq and imu_bias_calibrator.
`timescale 1ns / 1ps

package ibc_pkg;

    localparam int SAMPLE_W  = 16;          // raw and compensated sample width
    localparam int SUM_W     = 26;          // signed accumulator width
    localparam int MAG_W     = SUM_W - 1;   // accumulator magnitude width
    localparam int GRAV_W    = 15;          // gravity reference width
    localparam int NUM_AXES  = 6;           // gyro x/y/z then accel x/y/z
    localparam int GYRO_AXES = 3;
    localparam int ACCEL_Z   = 5;           // lane that removes gravity

    localparam logic [GRAV_W-1:0] GRAVITY_REF_RESET = 15'd16384;

    // Per-group control into the axis lanes
    typedef struct packed {
        logic clear;    // start of run: zero offset and sum
        logic accum;    // add compensated sample to sum
        logic div_mul;  // divide pipeline, multiply stage
        logic div_wr;   // divide pipeline, offset write stage
    } ibc_lane_ctl_t;

    // Per-item calibration status from the sequencer
    typedef struct packed {
        logic gyro_busy;
        logic accel_busy;
        logic gyro_done;
        logic accel_done;
    } ibc_status_t;

    // One result item as held in the output stage
    typedef struct packed {
        logic [NUM_AXES-1:0][SAMPLE_W-1:0] comp;
        ibc_status_t                       status;
    } ibc_result_t;

endpackage

FILE: rtl/ibc_axis_lane.sv
// ibc_axis_lane: one axis of the calibrator - offset removal, bias sum and
// averaging by reciprocal multiply. Depends on ibc_pkg.
`timescale 1ns / 1ps

module ibc_axis_lane #(
    parameter int CAL_SAMPLES = 200
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [ibc_pkg::SAMPLE_W-1:0]  sample,
    input  logic        [ibc_pkg::GRAV_W-1:0]    bias,
    input  ibc_pkg::ibc_lane_ctl_t               ctl,
    output logic signed [ibc_pkg::SAMPLE_W-1:0]  comp
);

    localparam int SW      = ibc_pkg::SAMPLE_W;
    localparam int SUMW    = ibc_pkg::SUM_W;
    localparam int MAGW    = ibc_pkg::MAG_W;
    localparam int DIV_L   = $clog2(CAL_SAMPLES);
    localparam int SHIFT   = MAGW + DIV_L;
    localparam int RECIP_W = MAGW + 1;
    localparam int PROD_W  = MAGW + RECIP_W;
    // floor(2^SHIFT / N) + 1 gives exact truncating quotients for MAGW-bit values
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) / CAL_SAMPLES) + 64'd1);

    logic        [SW-1:0]     offset_reg, offset_next;
    logic signed [SUMW-1:0]   sum_reg, sum_next;
    logic        [PROD_W-1:0] prod_reg, prod_next;
    logic                     neg_reg;
    logic signed [SUMW-1:0]   comp_ext, bias_ext;
    logic        [SUMW-1:0]   mag_full;
    logic        [SW-1:0]     quot;

    assign comp     = SW'(sample - offset_reg);
    assign comp_ext = {{(SUMW-SW){comp[SW-1]}}, comp};
    assign bias_ext = {{(SUMW-ibc_pkg::GRAV_W){1'b0}}, bias};

    assign mag_full  = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
    assign prod_next = PROD_W'(mag_full[MAGW-1:0]) * PROD_W'(RECIP);
    assign quot      = prod_reg[SHIFT +: SW];

    always_comb begin
        sum_next    = sum_reg;
        offset_next = offset_reg;
        if (ctl.clear) begin
            sum_next    = '0;
            offset_next = '0;
        end else if (ctl.accum) begin
            sum_next = sum_reg + comp_ext - bias_ext;
        end
        if (ctl.div_wr) begin
            offset_next = neg_reg ? SW'(-quot) : quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            sum_reg    <= '0;
        end else begin
            offset_reg <= offset_next;
            sum_reg    <= sum_next;
        end
    end

    // divide datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (ctl.div_mul) begin
            prod_reg <= prod_next;
            neg_reg  <= sum_reg[SUMW-1];
        end
    end

endmodule

FILE: rtl/ibc_cal_seq.sv
// ibc_cal_seq: gyro/accel calibration run sequencer and lane control merge.
// Depends on ibc_pkg.
`timescale 1ns / 1ps

module ibc_cal_seq #(
    parameter int CAL_SAMPLES = 200
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_fire,
    input  logic                   gyro_req,
    input  logic                   accel_req,
    output ibc_pkg::ibc_lane_ctl_t gyro_ctl,
    output ibc_pkg::ibc_lane_ctl_t accel_ctl,
    output ibc_pkg::ibc_status_t   status,
    output logic                   stall
);

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             active;
        logic             clear;
        logic             accum;
        logic             done;
        logic             skip;
    } grp_step_t;

    function automatic grp_step_t grp_step(input logic act, input logic [CNT_W-1:0] cnt);
        grp_step_t r;
        r        = '0;
        r.active = act;
        r.cnt    = cnt;
        if (act) begin
            if (cnt == '0) begin
                r.clear = 1'b1;
                r.cnt   = CNT_W'(1);
                r.skip  = 1'b1;
            end else begin
                r.accum = 1'b1;
                if (cnt >= CNT_W'(CAL_SAMPLES)) begin
                    r.cnt    = '0;
                    r.active = 1'b0;
                    r.done   = 1'b1;
                    r.skip   = 1'b1;
                end else begin
                    r.cnt = cnt + 1'b1;
                end
            end
        end
        return r;
    endfunction

    logic [CNT_W-1:0] g_cnt_reg, a_cnt_reg;
    logic             g_active_reg, a_active_reg;
    logic             g_ph1_reg, g_ph2_reg, a_ph1_reg, a_ph2_reg;
    grp_step_t        g_step, a_raw, a_step;

    always_comb begin
        g_step = grp_step(g_active_reg | gyro_req, g_cnt_reg);
        a_raw  = grp_step(a_active_reg | accel_req, a_cnt_reg);
        a_step = a_raw;
        // start and finish items of a gyro run leave accel untouched
        if (g_step.skip) begin
            a_step        = '0;
            a_step.cnt    = a_cnt_reg;
            a_step.active = a_active_reg | accel_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_cnt_reg    <= '0;
            a_cnt_reg    <= '0;
            g_active_reg <= 1'b0;
            a_active_reg <= 1'b0;
            g_ph1_reg    <= 1'b0;
            g_ph2_reg    <= 1'b0;
            a_ph1_reg    <= 1'b0;
            a_ph2_reg    <= 1'b0;
        end else begin
            if (in_fire) begin
                g_cnt_reg    <= g_step.cnt;
                a_cnt_reg    <= a_step.cnt;
                g_active_reg <= g_step.active;
                a_active_reg <= a_step.active;
            end
            g_ph1_reg <= in_fire & g_step.done;
            a_ph1_reg <= in_fire & a_step.done;
            g_ph2_reg <= g_ph1_reg;
            a_ph2_reg <= a_ph1_reg;
        end
    end

    assign gyro_ctl.clear    = in_fire & g_step.clear;
    assign gyro_ctl.accum    = in_fire & g_step.accum;
    assign gyro_ctl.div_mul  = g_ph1_reg;
    assign gyro_ctl.div_wr   = g_ph2_reg;
    assign accel_ctl.clear   = in_fire & a_step.clear;
    assign accel_ctl.accum   = in_fire & a_step.accum;
    assign accel_ctl.div_mul = a_ph1_reg;
    assign accel_ctl.div_wr  = a_ph2_reg;

    assign status.gyro_busy  = g_step.active;
    assign status.accel_busy = a_step.active;
    assign status.gyro_done  = g_step.done;
    assign status.accel_done = a_step.done;

    // hold off new items while a new offset set is being computed
    assign stall = g_ph1_reg | g_ph2_reg | a_ph1_reg | a_ph2_reg;

    a_done_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (status.gyro_done || status.accel_done) |=> ##1 stall)
        else $error("offset divide not covered by input stall");

    a_one_edge_group: assert property (@(posedge aclk) disable iff (!aresetn)
        gyro_ctl.clear |-> !(accel_ctl.clear || accel_ctl.accum))
        else $error("accel step ran on gyro start item");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (g_cnt_reg <= CNT_W'(CAL_SAMPLES)) && (a_cnt_reg <= CNT_W'(CAL_SAMPLES)))
        else $error("sample count beyond run length");

    a_no_fire_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |-> !in_fire)
        else $error("item accepted during offset divide");

endmodule

FILE: rtl/imu_bias_calibrator.sv
// imu_bias_calibrator: top level - six axis lanes, run sequencer, output skid stage
// and gravity reference register. Depends on ibc_pkg, ibc_axis_lane, ibc_cal_seq.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake            Contents
// s_*       in         s_valid / s_ready    6 raw samples + 2 calibration requests
// m_*       out        m_valid / m_ready    6 compensated samples + busy/done flags
// cfg_*     in         cfg_valid/cfg_ready  gravity_ref write data (15 bits)
//
// Throughput: one item per clock outside the stalls below; one result per transfer.
// Result is registered: shown the cycle after its transfer unless it waits in the skid.
// After an item that completes a calibration run, s_ready drops while each lane's
//   reciprocal multiply and sign fix produce the new offsets.
// Output is a two-entry skid stage: input is still taken while only one result waits.
// Reset (aresetn low, synchronous): offsets, sums, counts and runs clear,
//   gravity_ref returns to 16384. cfg_ready is always high.

module imu_bias_calibrator #(
    parameter int CAL_SAMPLES = 200
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input samples
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ibc_pkg::SAMPLE_W-1:0]  s_gyro_x,
    input  logic signed [ibc_pkg::SAMPLE_W-1:0]  s_gyro_y,
    input  logic signed [ibc_pkg::SAMPLE_W-1:0]  s_gyro_z,
    input  logic signed [ibc_pkg::SAMPLE_W-1:0]  s_accel_x,
    input  logic signed [ibc_pkg::SAMPLE_W-1:0]  s_accel_y,
    input  logic signed [ibc_pkg::SAMPLE_W-1:0]  s_accel_z,
    input  logic                                 s_gyro_cal_request,
    input  logic                                 s_accel_cal_request,
    // results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ibc_pkg::SAMPLE_W-1:0]  m_gyro_x_comp,
    output logic signed [ibc_pkg::SAMPLE_W-1:0]  m_gyro_y_comp,
    output logic signed [ibc_pkg::SAMPLE_W-1:0]  m_gyro_z_comp,
    output logic signed [ibc_pkg::SAMPLE_W-1:0]  m_accel_x_comp,
    output logic signed [ibc_pkg::SAMPLE_W-1:0]  m_accel_y_comp,
    output logic signed [ibc_pkg::SAMPLE_W-1:0]  m_accel_z_comp,
    output logic                                 m_gyro_cal_busy,
    output logic                                 m_accel_cal_busy,
    output logic                                 m_gyro_cal_done,
    output logic                                 m_accel_cal_done,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [ibc_pkg::GRAV_W-1:0]    cfg_data
);

    localparam int SW = ibc_pkg::SAMPLE_W;

    logic                                      in_fire, m_fire, stall;
    logic [ibc_pkg::GRAV_W-1:0]                gravity_ref_reg;
    logic signed [SW-1:0]                      samples [ibc_pkg::NUM_AXES];
    logic signed [SW-1:0]                      comps   [ibc_pkg::NUM_AXES];
    ibc_pkg::ibc_lane_ctl_t                    gyro_ctl, accel_ctl;
    ibc_pkg::ibc_status_t                      status;
    ibc_pkg::ibc_result_t                      res_next, out_reg, skid_reg;
    logic                                      out_valid_reg, skid_valid_reg;

    // Only one register, so the port takes every write at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_ref_reg <= ibc_pkg::GRAVITY_REF_RESET;
        end else if (cfg_valid) begin
            gravity_ref_reg <= cfg_data;
        end
    end

    assign s_ready = !skid_valid_reg && !stall;
    assign in_fire = s_valid && s_ready;
    assign m_fire  = out_valid_reg && m_ready;

    assign samples[0] = s_gyro_x;
    assign samples[1] = s_gyro_y;
    assign samples[2] = s_gyro_z;
    assign samples[3] = s_accel_x;
    assign samples[4] = s_accel_y;
    assign samples[5] = s_accel_z;

    // Run sequencer: decides per transfer which group clears, accumulates
    // or finishes; gyro takes priority on its start and finish items.
    ibc_cal_seq #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .gyro_req  (s_gyro_cal_request),
        .accel_req (s_accel_cal_request),
        .gyro_ctl  (gyro_ctl),
        .accel_ctl (accel_ctl),
        .status    (status),
        .stall     (stall)
    );

    // One lane per axis. Only accel z removes the gravity reference from
    // what it sums.
    for (genvar i = 0; i < ibc_pkg::NUM_AXES; i++) begin : g_lane
        ibc_axis_lane #(
            .CAL_SAMPLES (CAL_SAMPLES)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .sample  (samples[i]),
            .bias    ((i == ibc_pkg::ACCEL_Z) ? gravity_ref_reg : '0),
            .ctl     ((i < ibc_pkg::GYRO_AXES) ? gyro_ctl : accel_ctl),
            .comp    (comps[i])
        );
        assign res_next.comp[i] = comps[i];
    end

    assign res_next.status = status;

    // Output skid stage: a result goes to the output register when it is free
    // or draining this cycle, otherwise to the skid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_reg <= skid_reg;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !m_ready) begin
                skid_reg <= res_next;
            end else begin
                out_reg <= res_next;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_gyro_x_comp    = out_reg.comp[0];
    assign m_gyro_y_comp    = out_reg.comp[1];
    assign m_gyro_z_comp    = out_reg.comp[2];
    assign m_accel_x_comp   = out_reg.comp[3];
    assign m_accel_y_comp   = out_reg.comp[4];
    assign m_accel_z_comp   = out_reg.comp[5];
    assign m_gyro_cal_busy  = out_reg.status.gyro_busy;
    assign m_accel_cal_busy = out_reg.status.accel_busy;
    assign m_gyro_cal_done  = out_reg.status.gyro_done;
    assign m_accel_cal_done = out_reg.status.accel_done;

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && out_valid_reg && !m_ready && !skid_valid_reg |=> skid_valid_reg)
        else $error("stalled result not parked in skid register");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_fire))
        else $error("result appeared without an input transfer");

endmodule
